// ===== rtl/psec_pkg.sv =====
// Shared types and constants for the pcap stream extent checker.
`default_nettype none

package psec_pkg;

  localparam int OFFSET_BITS_DEFAULT = 34;
  localparam int END_OFFSET_W        = 34;
  localparam int SNAP_LIMIT_W        = 23;
  localparam int RECORD_LIMIT_W      = 24;
  localparam int CFG_DATA_W          = 24;
  localparam int CFG_INDEX_W         = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_SNAP_LIMIT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECORD_LIMIT = 1'b1;

  localparam logic [SNAP_LIMIT_W-1:0]   SNAP_LIMIT_RESET   = 23'd4194304;
  localparam logic [RECORD_LIMIT_W-1:0] RECORD_LIMIT_RESET = 24'd10000000;

  localparam logic [31:0] MAGIC_SWAPPED    = 32'hD4C3B2A1;
  localparam logic [31:0] MAGIC_SWAPPED_NS = 32'h4D3CB2A1;

  localparam int GLOBAL_HDR_BYTES = 24;
  localparam int REC_HDR_BYTES    = 16;

  // byte positions within the global header
  localparam logic [4:0] POS_MAGIC_LAST  = 5'd3;
  localparam logic [4:0] POS_SNAP_LAST   = 5'd19;
  localparam logic [4:0] POS_GLOBAL_LAST = 5'd23;
  // byte positions within a record header
  localparam logic [3:0] POS_INCL_LAST   = 4'd11;
  localparam logic [3:0] POS_REC_LAST    = 4'd15;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_GLOBAL,
    PH_RECHDR,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic                    valid_res;
    logic [END_OFFSET_W-1:0] end_offset;
  } result_t;

  typedef struct packed {
    logic [SNAP_LIMIT_W-1:0]   snap_limit;
    logic [RECORD_LIMIT_W-1:0] record_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/psec_ifs.sv =====
// Request channels: capture bytes in, extent results out.
`default_nettype none

interface psec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source (output valid, output data_byte, output first, output last, input ready);
  modport sink   (input valid, input data_byte, input first, input last, output ready);
endinterface

interface psec_res_if;
  logic                             valid;
  logic                             ready;
  logic                             valid_res;
  logic [psec_pkg::END_OFFSET_W-1:0] end_offset;

  modport source (output valid, output valid_res, output end_offset, input ready);
  modport sink   (input valid, input valid_res, input end_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/psec_in_stage.sv =====
// Input register holding one capture byte request.
`default_nettype none

module psec_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  psec_byte_if.sink           item,
  input  wire logic           down_free,
  output psec_pkg::byte_item_t q_item,
  output logic                take
);

  logic q_valid;

  assign take       = q_valid && down_free;
  assign item.ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.ready) begin
      q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      q_item.data_byte <= item.data_byte;
      q_item.first     <= item.first;
      q_item.last      <= item.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psec_walker.sv =====
// Header parser and record walker: one byte per step.
`default_nettype none

module psec_walker #(
  parameter int OFFSET_BITS = psec_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire psec_pkg::byte_item_t item,
  input  wire psec_pkg::cfg_t       cfg,
  output logic                      fin,
  output psec_pkg::result_t         res
);

  localparam int OutW = psec_pkg::END_OFFSET_W;

  psec_pkg::phase_t        phase, cur_phase, phase_next;
  logic [4:0]              field_pos, cur_pos, field_pos_next;
  logic                    byte_swapped, cur_swapped, byte_swapped_next;
  logic [31:0]             field_shift, cur_shift, field_shift_next;
  logic [31:0]             snap_length, cur_snap, snap_length_next;
  logic [31:0]             included_length, cur_incl, included_length_next;
  logic [OFFSET_BITS-1:0]  record_start, cur_rstart, record_start_next;
  logic [22:0]             payload_left, cur_pleft, payload_left_next;
  logic [23:0]             records_seen, cur_seen, records_seen_next;

  logic [1:0]              lane;
  logic                    big;
  logic [31:0]             gbase, gathered;
  logic [3:0]              rpos;
  logic [22:0]             pleft_dec;
  logic                    stop;
  logic [OutW+OFFSET_BITS-1:0] rstart_wide;

  // a first byte restarts the walk from clean state
  always_comb begin
    if (item.first) begin
      cur_phase   = psec_pkg::PH_GLOBAL;
      cur_pos     = '0;
      cur_swapped = 1'b0;
      cur_shift   = '0;
      cur_snap    = '0;
      cur_incl    = '0;
      cur_rstart  = '0;
      cur_pleft   = '0;
      cur_seen    = '0;
    end else begin
      cur_phase   = phase;
      cur_pos     = field_pos;
      cur_swapped = byte_swapped;
      cur_shift   = field_shift;
      cur_snap    = snap_length;
      cur_incl    = included_length;
      cur_rstart  = record_start;
      cur_pleft   = payload_left;
      cur_seen    = records_seen;
    end
  end

  // field assembly in either byte order
  always_comb begin
    lane  = cur_pos[1:0];
    gbase = (lane == 2'd0) ? '0 : cur_shift;
    if (cur_phase == psec_pkg::PH_GLOBAL) begin
      big = (cur_pos > psec_pkg::POS_MAGIC_LAST) && cur_swapped;
    end else begin
      big = cur_swapped;
    end
    if (big) begin
      gathered = {gbase[23:0], item.data_byte};
    end else begin
      gathered = gbase | ({24'd0, item.data_byte} << {lane, 3'b000});
    end
  end

  assign rpos      = cur_pos[3:0];
  assign pleft_dec = cur_pleft - {22'd0, (cur_pleft != '0)};

  // next state
  always_comb begin
    phase_next           = cur_phase;
    field_pos_next       = cur_pos;
    byte_swapped_next    = cur_swapped;
    field_shift_next     = cur_shift;
    snap_length_next     = cur_snap;
    included_length_next = cur_incl;
    record_start_next    = cur_rstart;
    payload_left_next    = cur_pleft;
    records_seen_next    = cur_seen;
    stop                 = 1'b0;

    unique case (cur_phase)
      psec_pkg::PH_DONE: begin
      end
      psec_pkg::PH_GLOBAL: begin
        field_shift_next = gathered;
        if (cur_pos == psec_pkg::POS_MAGIC_LAST) begin
          byte_swapped_next = (gathered == psec_pkg::MAGIC_SWAPPED) ||
                              (gathered == psec_pkg::MAGIC_SWAPPED_NS);
        end else if (cur_pos == psec_pkg::POS_SNAP_LAST) begin
          snap_length_next = gathered;
        end
        if (cur_pos == psec_pkg::POS_GLOBAL_LAST) begin
          if (cur_snap == '0 || cur_snap > {9'd0, cfg.snap_limit}) begin
            stop = 1'b1;
          end else begin
            record_start_next = OFFSET_BITS'(psec_pkg::GLOBAL_HDR_BYTES);
            field_pos_next    = '0;
            phase_next        = psec_pkg::PH_RECHDR;
            if (cur_seen >= cfg.record_limit) begin
              stop = 1'b1;
            end
          end
        end else begin
          field_pos_next = cur_pos + 5'd1;
        end
      end
      psec_pkg::PH_RECHDR: begin
        field_shift_next = gathered;
        if (rpos == psec_pkg::POS_INCL_LAST) begin
          included_length_next = gathered;
        end
        if (rpos == psec_pkg::POS_REC_LAST) begin
          field_pos_next = '0;
          if (cur_incl == '0 || cur_incl > cur_snap || gathered < cur_incl) begin
            stop = 1'b1;
          end else begin
            records_seen_next = cur_seen + 24'd1;
            record_start_next = cur_rstart + OFFSET_BITS'(psec_pkg::REC_HDR_BYTES) +
                                OFFSET_BITS'(cur_incl);
            payload_left_next = cur_incl[22:0];
            if (records_seen_next >= cfg.record_limit) begin
              stop = 1'b1;
            end
            phase_next = (payload_left_next == '0) ? psec_pkg::PH_RECHDR
                                                   : psec_pkg::PH_PAYLOAD;
          end
        end else begin
          field_pos_next = {1'b0, rpos} + 5'd1;
        end
      end
      psec_pkg::PH_PAYLOAD: begin
        payload_left_next = pleft_dec;
        if (pleft_dec == '0) begin
          field_pos_next = '0;
          phase_next     = psec_pkg::PH_RECHDR;
        end
      end
      default: begin
      end
    endcase

    fin = stop || (cur_phase != psec_pkg::PH_DONE && item.last);
    if (fin) begin
      phase_next = psec_pkg::PH_DONE;
    end
  end

  // result
  always_comb begin
    rstart_wide   = {{OutW{1'b0}}, record_start_next};
    res.valid_res = (records_seen_next != '0);
    res.end_offset = res.valid_res ? rstart_wide[OutW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= psec_pkg::PH_DONE;
      field_pos       <= '0;
      byte_swapped    <= 1'b0;
      field_shift     <= '0;
      snap_length     <= '0;
      included_length <= '0;
      record_start    <= '0;
      payload_left    <= '0;
      records_seen    <= '0;
    end else if (step) begin
      phase           <= phase_next;
      field_pos       <= field_pos_next;
      byte_swapped    <= byte_swapped_next;
      field_shift     <= field_shift_next;
      snap_length     <= snap_length_next;
      included_length <= included_length_next;
      record_start    <= record_start_next;
      payload_left    <= payload_left_next;
      records_seen    <= records_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psec_out_stage.sv =====
// Result register driving the extent result channel.
`default_nettype none

module psec_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire psec_pkg::result_t data,
  output logic                   free,
  psec_res_if.source             result
);

  logic valid;

  assign free         = !valid || result.ready;
  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= load || (valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.valid_res  <= data.valid_res;
      result.end_offset <= data.end_offset;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcap_stream_extent_checker.sv =====
// Top level of the pcap stream extent checker.
//
// Bytes of a candidate capture arrive on the item channel, one per request,
// with first marking offset zero and last the final available byte. The
// block parses the 24-byte global header, walks the record headers and
// returns at most one request on the result channel per candidate: valid_res
// and the offset just past the last accepted record. Throughput is one byte
// per cycle; all per-byte work sits between the input register and the
// result register. The walk's last byte loads the result register as it
// leaves the input register. snap_limit (index 0) and record_limit (index 1)
// are written through the cfg_write/cfg_index/cfg_data port; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset empties both registers, loads the default limits and leaves the
// walker waiting for a first byte; bytes without first are then dropped.
// While the result receiver stalls a pending result, one further byte is
// held in the input register and item.ready falls.
`default_nettype none

module pcap_stream_extent_checker #(
  parameter int OFFSET_BITS = psec_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [psec_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [psec_pkg::CFG_DATA_W-1:0]   cfg_data,
  psec_byte_if.sink                              item,
  psec_res_if.source                             result
);

  psec_pkg::cfg_t       cfg;
  psec_pkg::byte_item_t q_item;
  psec_pkg::result_t    res;
  logic                 take;
  logic                 free;
  logic                 fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.snap_limit   <= psec_pkg::SNAP_LIMIT_RESET;
      cfg.record_limit <= psec_pkg::RECORD_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psec_pkg::REG_SNAP_LIMIT:   cfg.snap_limit   <= cfg_data[psec_pkg::SNAP_LIMIT_W-1:0];
        psec_pkg::REG_RECORD_LIMIT: cfg.record_limit <= cfg_data[psec_pkg::RECORD_LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psec_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .down_free (free),
    .q_item    (q_item),
    .take      (take)
  );

  psec_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (q_item),
    .cfg  (cfg),
    .fin  (fin),
    .res  (res)
  );

  psec_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take && fin),
    .data   (res),
    .free   (free),
    .result (result)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.valid_res |-> result.end_offset == '0)
    else $error("invalid result with nonzero end offset");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result pending right after reset");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready && !free |-> !take)
    else $error("byte processed while result register is blocked");
`endif

endmodule

`default_nettype wire

// ===== bench/extent_watch.sv =====
// Extent watcher: mirrors the capture walk, predicts each result and checks it.
`timescale 1ns / 1ps

module extent_watch (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [psec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psec_pkg::CFG_DATA_W-1:0]  cfg_data,
  psec_byte_if                             cap,
  psec_res_if                              ext,
  output int                               mismatches,
  output int                               extents_owed
);

  logic [psec_pkg::SNAP_LIMIT_W-1:0]   snap_lim;
  logic [psec_pkg::RECORD_LIMIT_W-1:0] rec_lim;

  psec_pkg::phase_t                  ph;
  logic [4:0]                        fpos;
  logic                              swapped;
  logic [31:0]                       fshift;
  logic [31:0]                       snap_len;
  logic [31:0]                       incl_len;
  logic [psec_pkg::END_OFFSET_W-1:0] rec_end;
  logic [22:0]                       pay_left;
  logic [23:0]                       recs;
  psec_pkg::result_t                 due_extents[$];
  int                                errs;

  task automatic gather(input logic [1:0] k, input logic [7:0] b, input logic big);
    if (k == 2'd0) fshift = '0;
    if (big) fshift = {fshift[23:0], b};
    else fshift = fshift | ({24'd0, b} << (8 * k));
  endtask

  task automatic take_byte(input psec_pkg::byte_item_t it);
    logic [4:0]        pos;
    logic              stop;
    psec_pkg::result_t r;
    stop = 1'b0;
    if (it.first) begin
      ph       = psec_pkg::PH_GLOBAL;
      fpos     = '0;
      swapped  = 1'b0;
      fshift   = '0;
      snap_len = '0;
      incl_len = '0;
      rec_end  = '0;
      pay_left = '0;
      recs     = '0;
    end
    if (ph == psec_pkg::PH_DONE) return;
    pos = fpos;
    case (ph)
      psec_pkg::PH_GLOBAL: begin
        gather(pos[1:0], it.data_byte, (pos >= 5'd4) && swapped);
        if (pos == psec_pkg::POS_MAGIC_LAST)
          swapped = (fshift == psec_pkg::MAGIC_SWAPPED) ||
                    (fshift == psec_pkg::MAGIC_SWAPPED_NS);
        else if (pos == psec_pkg::POS_SNAP_LAST)
          snap_len = fshift;
        if (pos == psec_pkg::POS_GLOBAL_LAST) begin
          if (snap_len == '0 || snap_len > {9'd0, snap_lim}) begin
            stop = 1'b1;
          end else begin
            rec_end = psec_pkg::END_OFFSET_W'(psec_pkg::GLOBAL_HDR_BYTES);
            fpos    = '0;
            ph      = psec_pkg::PH_RECHDR;
            stop    = (recs >= rec_lim);
          end
        end else begin
          fpos = pos + 5'd1;
        end
      end
      psec_pkg::PH_RECHDR: begin
        gather(pos[1:0], it.data_byte, swapped);
        if (pos[3:0] == psec_pkg::POS_INCL_LAST) incl_len = fshift;
        if (pos[3:0] == psec_pkg::POS_REC_LAST) begin
          fpos = '0;
          if (incl_len == '0 || incl_len > snap_len || fshift < incl_len) begin
            stop = 1'b1;
          end else begin
            recs     = recs + 24'd1;
            rec_end  = rec_end + psec_pkg::END_OFFSET_W'(psec_pkg::REC_HDR_BYTES) +
                       {2'b00, incl_len};
            pay_left = incl_len[22:0];
            if (recs >= rec_lim) stop = 1'b1;
            else if (pay_left == '0) ph = psec_pkg::PH_RECHDR;
            else ph = psec_pkg::PH_PAYLOAD;
          end
        end else begin
          fpos = pos + 5'd1;
        end
      end
      default: begin
        if (pay_left != '0) pay_left = pay_left - 23'd1;
        if (pay_left == '0) begin
          fpos = '0;
          ph   = psec_pkg::PH_RECHDR;
        end
      end
    endcase
    if (stop || it.last) begin
      r.valid_res  = (recs != '0);
      r.end_offset = r.valid_res ? rec_end : '0;
      due_extents  = {due_extents, r};
      ph = psec_pkg::PH_DONE;
    end
  endtask

  always @(posedge clk) begin : watch_edge
    psec_pkg::byte_item_t it;
    psec_pkg::result_t    got;
    psec_pkg::result_t    want;
    if (rst) begin
      snap_lim = psec_pkg::SNAP_LIMIT_RESET;
      rec_lim  = psec_pkg::RECORD_LIMIT_RESET;
      ph       = psec_pkg::PH_DONE;
      fpos     = '0;
      swapped  = 1'b0;
      fshift   = '0;
      snap_len = '0;
      incl_len = '0;
      rec_end  = '0;
      pay_left = '0;
      recs     = '0;
      due_extents.delete();
      errs = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == psec_pkg::REG_SNAP_LIMIT)
          snap_lim = cfg_data[psec_pkg::SNAP_LIMIT_W-1:0];
        else if (cfg_index == psec_pkg::REG_RECORD_LIMIT)
          rec_lim = cfg_data[psec_pkg::RECORD_LIMIT_W-1:0];
      end
      if (cap.valid && cap.ready) begin
        it.data_byte = cap.data_byte;
        it.first     = cap.first;
        it.last      = cap.last;
        take_byte(it);
      end
      if (ext.valid && ext.ready) begin
        got.valid_res  = ext.valid_res;
        got.end_offset = ext.end_offset;
        if (due_extents.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got valid_res=%0b end_offset=%0d",
                   $time, got.valid_res, got.end_offset);
        end else begin
          want = due_extents.pop_front();
          if (got.valid_res !== want.valid_res) begin
            errs++;
            $display("%0t: valid_res expected %0b got %0b",
                     $time, want.valid_res, got.valid_res);
          end
          if (got.end_offset !== want.end_offset) begin
            errs++;
            $display("%0t: end_offset expected %0d got %0d",
                     $time, want.end_offset, got.end_offset);
          end
        end
      end
    end
    mismatches   <= errs;
    extents_owed <= due_extents.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the extent checker bench: clock, reset, capture stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam logic [31:0] MAGIC_NATIVE    = 32'hA1B2C3D4;
  localparam logic [31:0] MAGIC_NATIVE_NS = 32'hA1B23C4D;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 140;
  localparam int PHASE_CAPTURES = 3;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_write;
  logic [psec_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [psec_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                               mismatches;
  int                               extents_owed;

  psec_byte_if cap_bus ();
  psec_res_if  ext_bus ();

  psec_pkg::byte_item_t capture[$];
  int                   lim_snap;
  int                   phase_bytes;
  int                   phase_caps;
  bit                   tx_gaps = 1'b1;
  bit                   rx_gaps = 1'b1;
  int                   holds_asked = 0;
  int                   holds_done = 0;

  pcap_stream_extent_checker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (cap_bus),
    .result    (ext_bus)
  );

  extent_watch watch (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cap          (cap_bus),
    .ext          (ext_bus),
    .mismatches   (mismatches),
    .extents_owed (extents_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("pcap_stream_extent_checker verification failed");
    $finish;
  end

  // result receiver: random stalls, plus long hold-offs on request
  initial begin
    ext_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        ext_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        ext_bus.ready <= rx_gaps ? ($urandom_range(99) >= 21) : 1'b1;
      end
    end
  end

  task automatic put_word(input logic [31:0] w, input bit big);
    psec_pkg::byte_item_t it;
    it.first = 1'b0;
    it.last  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      it.data_byte = big ? w[31 - 8 * i -: 8] : w[8 * i +: 8];
      capture = {capture, it};
    end
  endtask

  task automatic put_random(input int n);
    psec_pkg::byte_item_t it;
    it.first = 1'b0;
    it.last  = 1'b0;
    repeat (n) begin
      it.data_byte = 8'($urandom());
      capture = {capture, it};
    end
  endtask

  task automatic open_capture(input logic [31:0] magic, input logic [31:0] snap, input bit big);
    capture.delete();
    put_word(magic, 1'b0);
    put_random(12);
    put_word(snap, big);
    put_random(4);
  endtask

  task automatic add_record(input logic [31:0] incl, input logic [31:0] orig, input bit big,
                            input int pay);
    put_random(8);
    put_word(incl, big);
    put_word(orig, big);
    put_random(pay);
  endtask

  task automatic push_byte(input psec_pkg::byte_item_t it);
    while (tx_gaps && $urandom_range(99) < 21) begin
      cap_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cap_bus.valid     <= 1'b1;
    cap_bus.data_byte <= it.data_byte;
    cap_bus.first     <= it.first;
    cap_bus.last      <= it.last;
    @(posedge clk);
    while (!cap_bus.ready) @(posedge clk);
  endtask

  task automatic send_capture(input int cut, input bit with_last);
    psec_pkg::byte_item_t it;
    if (cut > capture.size()) cut = capture.size();
    for (int i = 0; i < cut; i++) begin
      it       = capture[i];
      it.first = (i == 0);
      it.last  = with_last && (i == cut - 1);
      push_byte(it);
    end
    phase_bytes += cut;
    phase_caps++;
  endtask

  task automatic send_full();
    send_capture(capture.size(), 1'b1);
  endtask

  // bytes without first; the walker drops them while it is done
  task automatic send_noise(input int n);
    psec_pkg::byte_item_t it;
    repeat (n) begin
      it.data_byte = 8'($urandom());
      it.first     = 1'b0;
      it.last      = 1'($urandom_range(1));
      push_byte(it);
    end
  endtask

  task automatic settle();
    cap_bus.valid <= 1'b0;
    @(posedge clk);
    while (extents_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input int snap, input int recs);
    cfg_write <= 1'b1;
    cfg_index <= psec_pkg::REG_SNAP_LIMIT;
    cfg_data  <= psec_pkg::CFG_DATA_W'(snap);
    @(posedge clk);
    cfg_index <= psec_pkg::REG_RECORD_LIMIT;
    cfg_data  <= psec_pkg::CFG_DATA_W'(recs);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    lim_snap = snap;
  endtask

  task automatic pick_magic(output logic [31:0] magic, output bit big);
    case ($urandom_range(4))
      0:       magic = MAGIC_NATIVE;
      1:       magic = MAGIC_NATIVE_NS;
      2:       magic = psec_pkg::MAGIC_SWAPPED;
      3:       magic = psec_pkg::MAGIC_SWAPPED_NS;
      default: magic = $urandom();
    endcase
    big = (magic == psec_pkg::MAGIC_SWAPPED) || (magic == psec_pkg::MAGIC_SWAPPED_NS);
  endtask

  task automatic random_capture();
    logic [31:0] magic;
    logic [31:0] snap;
    logic [31:0] incl;
    logic [31:0] orig;
    bit          big;
    bit          snap_ok;
    int          nrec;
    int          cap_len;
    int          pick;
    pick_magic(magic, big);
    pick = $urandom_range(99);
    if (pick < 70) snap = $urandom_range(1, lim_snap < 24 ? lim_snap : 24);
    else if (pick < 78) snap = lim_snap;
    else if (pick < 84) snap = '0;
    else if (pick < 90) snap = lim_snap + 1;
    else if (pick < 95) snap = $urandom_range(1, lim_snap);
    else snap = $urandom();
    snap_ok = (snap != '0) && (snap <= lim_snap);
    open_capture(magic, snap, big);
    nrec = $urandom_range(3);
    for (int i = 0; i < nrec; i++) begin
      if (snap_ok) incl = $urandom_range(1, snap < 8 ? snap : 8);
      else incl = $urandom_range(1, 8);
      if (snap_ok && snap <= 64 && $urandom_range(9) == 0) incl = snap;
      case ($urandom_range(9))
        0:       orig = 32'hFFFF_FFFF;
        1:       orig = incl;
        default: orig = incl + $urandom_range(3);
      endcase
      pick = $urandom_range(99);
      if (pick < 3) incl = '0;
      else if (pick < 6 && snap != 32'hFFFF_FFFF) incl = snap + 1;
      else if (pick < 9) orig = incl - 1;
      if (pick < 9) begin
        add_record(incl, orig, big, 0);
        break;
      end
      add_record(incl, orig, big, incl);
    end
    cap_len = capture.size();
    pick = $urandom_range(99);
    if (pick < 84) send_capture(cap_len, 1'b1);
    else if (pick < 90) send_capture($urandom_range(1, cap_len), 1'b1);
    else if (pick < 95) send_capture(cap_len, 1'b0);
    else send_capture($urandom_range(1, cap_len), 1'b0);
    if ($urandom_range(99) < 12) send_noise($urandom_range(1, 3));
  endtask

  task automatic random_phase(input int snap, input int recs, input bit calm, input int holds);
    psec_pkg::byte_item_t it;
    settle();
    set_limits(snap, recs);
    tx_gaps = !calm;
    rx_gaps = !calm;
    holds_asked += holds;
    phase_bytes = 0;
    phase_caps  = 0;
    while (phase_bytes < PHASE_BYTES || phase_caps < PHASE_CAPTURES) random_capture();
    // one-byte capture closes any walk left open
    it.data_byte = 8'($urandom());
    it.first     = 1'b1;
    it.last      = 1'b1;
    push_byte(it);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    cap_bus.valid     = 1'b0;
    cap_bus.data_byte = '0;
    cap_bus.first     = 1'b0;
    cap_bus.last      = 1'b0;
    lim_snap          = psec_pkg::SNAP_LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    open_capture(MAGIC_NATIVE, 16, 1'b0);
    add_record(1, 1, 1'b0, 1);
    add_record(16, 20, 1'b0, 16);
    send_full();
    open_capture(psec_pkg::MAGIC_SWAPPED, psec_pkg::SNAP_LIMIT_RESET, 1'b1);
    add_record(7, 7, 1'b1, 7);
    add_record(3, 32'hFFFF_FFFF, 1'b1, 3);
    send_full();
    open_capture(psec_pkg::MAGIC_SWAPPED_NS, 8, 1'b1);
    add_record(8, 9, 1'b1, 8);
    send_full();
    open_capture(MAGIC_NATIVE_NS, 5, 1'b0);
    add_record(5, 5, 1'b0, 5);
    send_full();
    // snap length zero, above the limit, all ones
    open_capture(MAGIC_NATIVE, 0, 1'b0);
    add_record(4, 4, 1'b0, 4);
    send_full();
    open_capture(psec_pkg::MAGIC_SWAPPED, psec_pkg::SNAP_LIMIT_RESET + 1, 1'b1);
    add_record(4, 4, 1'b1, 4);
    send_full();
    open_capture(MAGIC_NATIVE, 32'hFFFF_FFFF, 1'b0);
    send_full();
    // global header cut short, then header with no records
    open_capture(MAGIC_NATIVE, 16, 1'b0);
    send_capture(10, 1'b1);
    open_capture(psec_pkg::MAGIC_SWAPPED, 16, 1'b1);
    send_full();
    send_noise(3);
    // bad record headers end the walk at their start
    open_capture(MAGIC_NATIVE, 16, 1'b0);
    add_record(2, 2, 1'b0, 2);
    add_record(0, 5, 1'b0, 0);
    send_full();
    open_capture(psec_pkg::MAGIC_SWAPPED, 16, 1'b1);
    add_record(2, 2, 1'b1, 2);
    add_record(17, 17, 1'b1, 0);
    put_random(5);
    send_full();
    open_capture(MAGIC_NATIVE, 16, 1'b0);
    add_record(2, 2, 1'b0, 2);
    add_record(6, 5, 1'b0, 6);
    send_full();
    // walk dropped by a new first, then data ending inside a payload
    open_capture(MAGIC_NATIVE, 16, 1'b0);
    add_record(3, 3, 1'b0, 3);
    add_record(9, 9, 1'b0, 9);
    send_capture(30, 1'b0);
    send_capture(capture.size() - 4, 1'b1);
    // data ending inside a record header
    open_capture(psec_pkg::MAGIC_SWAPPED, 16, 1'b1);
    add_record(3, 3, 1'b1, 3);
    add_record(9, 9, 1'b1, 9);
    send_capture(psec_pkg::GLOBAL_HDR_BYTES + psec_pkg::REC_HDR_BYTES + 3 + 6, 1'b1);

    settle();
    set_limits(1, 1);
    open_capture(MAGIC_NATIVE, 1, 1'b0);
    repeat (3) add_record(1, 1, 1'b0, 1);
    send_full();
    open_capture(psec_pkg::MAGIC_SWAPPED, 2, 1'b1);
    add_record(1, 1, 1'b1, 1);
    send_full();
    settle();
    set_limits(20, 0);
    open_capture(MAGIC_NATIVE, 20, 1'b0);
    add_record(4, 4, 1'b0, 4);
    send_full();

    random_phase(psec_pkg::SNAP_LIMIT_RESET, 16777215, 1'b0, 1);
    random_phase(12, 3, 1'b1, 0);
    random_phase($urandom_range(1, 4194304), $urandom_range(1, 16777215), 1'b0, 0);
    random_phase(2, 2, 1'b0, 0);
    random_phase(psec_pkg::SNAP_LIMIT_RESET, psec_pkg::RECORD_LIMIT_RESET, 1'b0, 1);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && extents_owed == 0)
      $display("pcap_stream_extent_checker verification clean");
    else
      $display("pcap_stream_extent_checker verification failed");
    $finish;
  end

endmodule
